// ===== hw/rtl/erie_pkg.sv =====
// Shared types and constants of the eight-bit RISC instruction executor.
`default_nettype none
package erie_pkg;

  // Architectural register count, fixed by the ISA
  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);

  // Queue between front and back; depth must be a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Item kinds on the input channel
  typedef enum logic [2:0] {
    KIND_EXEC = 3'd0,
    KIND_WREG = 3'd1,
    KIND_WMEM = 3'd2,
    KIND_RMEM = 3'd3,
    KIND_RREG = 3'd4
  } kind_t;

  // Internal operations; the first sixteen match the instruction opcodes
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_INC  = 5'd3,
    OP_AND  = 5'd4,
    OP_OR   = 5'd5,
    OP_XOR  = 5'd6,
    OP_NOT  = 5'd7,
    OP_SHL  = 5'd8,
    OP_SHR  = 5'd9,
    OP_LI   = 5'd10,
    OP_LD   = 5'd11,
    OP_ST   = 5'd12,
    OP_JMP  = 5'd13,
    OP_BEQZ = 5'd14,
    OP_HALT = 5'd15,
    OP_WREG = 5'd16,
    OP_WMEM = 5'd17,
    OP_RMEM = 5'd18,
    OP_RREG = 5'd19,
    OP_NOP  = 5'd20
  } op_t;

  // Instruction class reported with each result
  typedef enum logic [2:0] {
    CLS_ARITH = 3'd0,
    CLS_LOGIC = 3'd1,
    CLS_SHIFT = 3'd2,
    CLS_MEM   = 3'd3,
    CLS_CTRL  = 3'd4,
    CLS_HALT  = 3'd5,
    CLS_NONE  = 3'd6
  } class_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_READ = 2'd0,
    BK_EXEC = 2'd1,
    BK_MEM  = 2'd2
  } back_st_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    op_t                  op;
    class_t               cls;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] ra;
    logic [REG_IDX_W-1:0] rb;
    logic [7:0]           imm;
    logic [7:0]           addr;
    logic [7:0]           value;
  } dec_t;

  // One queue beat with its valid flag
  typedef struct packed {
    logic valid;
    dec_t entry;
  } q_beat_t;

  // Result register contents
  typedef struct packed {
    logic [7:0]           next_pc;
    logic                 halted;
    logic                 reg_written;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [7:0]           reg_result;
    logic                 mem_written;
    logic [7:0]           store_address;
    logic [7:0]           store_value;
    logic [7:0]           read_value;
    class_t               instr_class;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/erie_item_if.sv =====
// Input channel of the executor: handshake and item fields.
`default_nettype none
interface erie_item_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [15:0]       instruction;
  logic [3:0]        reg_select;
  logic [7:0]        mem_address;
  logic signed [7:0] load_value;

  modport source (
    output valid, kind, instruction, reg_select, mem_address, load_value,
    input  ready
  );

  modport sink (
    input  valid, kind, instruction, reg_select, mem_address, load_value,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/erie_result_if.sv =====
// Output channel of the executor: handshake and result fields.
`default_nettype none
interface erie_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        next_pc;
  logic              halted;
  logic              reg_written;
  logic [3:0]        dest_reg;
  logic signed [7:0] reg_result;
  logic              mem_written;
  logic [7:0]        store_address;
  logic signed [7:0] store_value;
  logic signed [7:0] read_value;
  logic [2:0]        instr_class;

  modport source (
    output valid, next_pc, halted, reg_written, dest_reg, reg_result,
           mem_written, store_address, store_value, read_value, instr_class,
    input  ready
  );

  modport sink (
    input  valid, next_pc, halted, reg_written, dest_reg, reg_result,
           mem_written, store_address, store_value, read_value, instr_class,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/erie_front.sv =====
// Front end: accepts input beats and classifies them for the back end.
`default_nettype none
module erie_front (
  erie_item_if.sink          item,
  input  logic               full,
  output erie_pkg::q_beat_t  push
);

  erie_pkg::dec_t dec;

  // Accept whenever the queue has room
  assign item.ready = !full;

  // Classify the beat
  always_comb begin
    dec.op    = erie_pkg::OP_NOP;
    dec.cls   = erie_pkg::CLS_NONE;
    dec.rd    = item.instruction[11:8];
    dec.ra    = item.instruction[7:4];
    dec.rb    = item.instruction[3:0];
    dec.imm   = item.instruction[7:0];
    dec.addr  = item.mem_address;
    dec.value = item.load_value;
    case (item.kind)
      erie_pkg::KIND_EXEC: begin
        dec.op = erie_pkg::op_t'({1'b0, item.instruction[15:12]});
        case (dec.op) inside
          [erie_pkg::OP_ADD:erie_pkg::OP_INC]: dec.cls = erie_pkg::CLS_ARITH;
          [erie_pkg::OP_AND:erie_pkg::OP_NOT]: dec.cls = erie_pkg::CLS_LOGIC;
          [erie_pkg::OP_SHL:erie_pkg::OP_SHR]: dec.cls = erie_pkg::CLS_SHIFT;
          [erie_pkg::OP_LI:erie_pkg::OP_ST]:   dec.cls = erie_pkg::CLS_MEM;
          [erie_pkg::OP_JMP:erie_pkg::OP_BEQZ]: dec.cls = erie_pkg::CLS_CTRL;
          erie_pkg::OP_HALT:                   dec.cls = erie_pkg::CLS_HALT;
          default:                             dec.cls = erie_pkg::CLS_NONE;
        endcase
        // Second read port carries rd for ops that read it
        if (dec.op inside {erie_pkg::OP_INC, erie_pkg::OP_ST, erie_pkg::OP_BEQZ}) begin
          dec.rb = item.instruction[11:8];
        end
        // Jump offset sits one nibble higher
        if (dec.op == erie_pkg::OP_JMP) begin
          dec.imm = item.instruction[11:4];
        end
      end
      erie_pkg::KIND_WREG: begin
        dec.op = erie_pkg::OP_WREG;
        dec.rd = item.reg_select;
      end
      erie_pkg::KIND_WMEM: dec.op = erie_pkg::OP_WMEM;
      erie_pkg::KIND_RMEM: dec.op = erie_pkg::OP_RMEM;
      erie_pkg::KIND_RREG: begin
        dec.op = erie_pkg::OP_RREG;
        dec.ra = item.reg_select;
      end
      default: dec.op = erie_pkg::OP_NOP;
    endcase
  end

  assign push.valid = item.valid && !full;
  assign push.entry = dec;

endmodule
`default_nettype wire

// ===== hw/rtl/erie_queue.sv =====
// Short FIFO of classified items between front and back end.
`default_nettype none
module erie_queue (
  input  logic               clk,
  input  logic               rst,
  input  erie_pkg::q_beat_t  push,
  input  logic               pop,
  output erie_pkg::q_beat_t  head,
  output logic               full
);

  erie_pkg::dec_t                slots [erie_pkg::QUEUE_DEPTH];
  logic [erie_pkg::QPTR_W-1:0]   wr_ptr;
  logic [erie_pkg::QPTR_W-1:0]   rd_ptr;
  logic [erie_pkg::QPTR_W:0]     count;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count == (erie_pkg::QPTR_W+1)'(erie_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.entry;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/erie_back.sv =====
// Back end: register file, data store and the execute sequencer.
`default_nettype none
module erie_back #(
  parameter int DATA_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  erie_pkg::q_beat_t  head,
  output logic               pop,
  erie_result_if.source      result
);

  localparam int IDX_W = $clog2(DATA_DEPTH);

  erie_pkg::back_st_t st, st_next;
  erie_pkg::dec_t     cur;
  erie_pkg::res_t     out_q, res;

  // Register file and data store with reset-clear valid bits
  logic [7:0]                     rf     [erie_pkg::REG_COUNT];
  logic [erie_pkg::REG_COUNT-1:0] rf_vld;
  logic [7:0]                     dmem   [DATA_DEPTH];
  logic [DATA_DEPTH-1:0]          dmem_vld;

  logic [7:0]       pc, pc_next;
  logic             halt_flag, halt_next;
  logic             out_valid;
  logic [7:0]       op_a, op_b;
  logic [7:0]       mem_q;
  logic             mem_vq;
  logic [7:0]       mem_byte;

  logic             run, out_ok, commit, mrd;
  logic [7:0]       sext, mem_raw, eff_raw;
  logic [IDX_W-1:0] eff_idx, rd_idx;
  logic [15:0]      prod;
  logic             rf_we, dm_we;
  logic [IDX_W-1:0] mod_lut [256];

  // Byte address to store index: constant table of address mod depth
  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign mod_lut[i] = IDX_W'(i % DATA_DEPTH);
  end

  assign mem_byte = mem_vq ? mem_q : 8'h00;
  assign out_ok   = !out_valid || result.ready;
  assign run      = (cur.op inside {[erie_pkg::OP_ADD:erie_pkg::OP_HALT]}) && !halt_flag;
  assign sext     = {{4{cur.imm[3]}}, cur.imm[3:0]};
  assign mem_raw  = op_a + sext;
  assign eff_raw  = (cur.op == erie_pkg::OP_LD || cur.op == erie_pkg::OP_ST) ?
                    mem_raw : cur.addr;
  assign eff_idx  = mod_lut[eff_raw];
  assign rd_idx   = pop ? mod_lut[head.entry.addr] : eff_idx;
  assign prod     = 16'(op_a) * 16'(op_b);

  // Sequence: read registers, execute, optional data store read
  always_comb begin
    st_next = st;
    pop     = 1'b0;
    mrd     = 1'b0;
    commit  = 1'b0;
    case (st)
      erie_pkg::BK_READ: begin
        if (head.valid) begin
          pop     = 1'b1;
          st_next = erie_pkg::BK_EXEC;
        end
      end
      erie_pkg::BK_EXEC: begin
        if (run && cur.op == erie_pkg::OP_LD) begin
          mrd     = 1'b1;
          st_next = erie_pkg::BK_MEM;
        end else if (out_ok) begin
          commit  = 1'b1;
          st_next = erie_pkg::BK_READ;
        end
      end
      erie_pkg::BK_MEM: begin
        if (out_ok) begin
          commit  = 1'b1;
          st_next = erie_pkg::BK_READ;
        end
      end
      default: st_next = erie_pkg::BK_READ;
    endcase
  end

  // Compute the result of the current item
  always_comb begin
    res               = '0;
    res.instr_class   = erie_pkg::CLS_NONE;
    pc_next           = pc;
    halt_next         = halt_flag;
    rf_we             = 1'b0;
    dm_we             = 1'b0;
    if (run) begin
      res.instr_class = cur.cls;
      res.dest_reg    = cur.rd;
      rf_we           = 1'b1;
      pc_next         = pc + 8'd2;
      case (cur.op)
        erie_pkg::OP_ADD:  res.reg_result = op_a + op_b;
        erie_pkg::OP_SUB:  res.reg_result = op_a - op_b;
        erie_pkg::OP_MUL:  res.reg_result = prod[7:0];
        erie_pkg::OP_INC:  res.reg_result = op_b + 8'd1;
        erie_pkg::OP_AND:  res.reg_result = op_a & op_b;
        erie_pkg::OP_OR:   res.reg_result = op_a | op_b;
        erie_pkg::OP_XOR:  res.reg_result = op_a ^ op_b;
        erie_pkg::OP_NOT:  res.reg_result = ~op_a;
        erie_pkg::OP_SHL:  res.reg_result = cur.imm[3] ? 8'h00 : (op_a << cur.imm[2:0]);
        erie_pkg::OP_SHR:  res.reg_result = cur.imm[3] ? 8'h00 : (op_a >> cur.imm[2:0]);
        erie_pkg::OP_LI:   res.reg_result = cur.imm;
        erie_pkg::OP_LD:   res.reg_result = mem_byte;
        erie_pkg::OP_ST: begin
          rf_we             = 1'b0;
          dm_we             = 1'b1;
          res.dest_reg      = '0;
          res.mem_written   = 1'b1;
          res.store_address = 8'(eff_idx);
          res.store_value   = op_b;
        end
        erie_pkg::OP_JMP: begin
          rf_we        = 1'b0;
          res.dest_reg = '0;
          pc_next      = pc + 8'd2 + {cur.imm[6:0], 1'b0};
        end
        erie_pkg::OP_BEQZ: begin
          rf_we        = 1'b0;
          res.dest_reg = '0;
          if (op_b == 8'h00) pc_next = pc + 8'd2 + {cur.imm[6:0], 1'b0};
        end
        default: begin
          rf_we        = 1'b0;
          res.dest_reg = '0;
          halt_next    = 1'b1;
        end
      endcase
      res.reg_written = rf_we;
    end else begin
      case (cur.op)
        erie_pkg::OP_WREG: begin
          rf_we           = 1'b1;
          res.reg_written = 1'b1;
          res.dest_reg    = cur.rd;
          res.reg_result  = cur.value;
        end
        erie_pkg::OP_WMEM: begin
          dm_we             = 1'b1;
          res.mem_written   = 1'b1;
          res.store_address = 8'(eff_idx);
          res.store_value   = cur.value;
        end
        erie_pkg::OP_RMEM: res.read_value = mem_byte;
        erie_pkg::OP_RREG: res.read_value = op_a;
        default:           res.read_value = 8'h00;
      endcase
    end
    res.next_pc = pc_next;
    res.halted  = halt_next;
  end

  // Control state, architectural state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= erie_pkg::BK_READ;
      pc        <= 8'h00;
      halt_flag <= 1'b0;
      out_valid <= 1'b0;
      rf_vld    <= '0;
      dmem_vld  <= '0;
    end else begin
      st <= st_next;
      if (commit) begin
        pc        <= pc_next;
        halt_flag <= halt_next;
        out_valid <= 1'b1;
        if (rf_we) rf_vld[res.dest_reg] <= 1'b1;
        if (dm_we) dmem_vld[eff_idx]    <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Register file: two registered reads, one write
  always_ff @(posedge clk) begin
    if (pop) begin
      op_a <= rf_vld[head.entry.ra] ? rf[head.entry.ra] : 8'h00;
      op_b <= rf_vld[head.entry.rb] ? rf[head.entry.rb] : 8'h00;
      cur  <= head.entry;
    end
    if (commit && rf_we) rf[res.dest_reg] <= res.reg_result;
  end

  // Data store: one registered read, one write
  always_ff @(posedge clk) begin
    if (pop || mrd) begin
      mem_q  <= dmem[rd_idx];
      mem_vq <= dmem_vld[rd_idx];
    end
    if (commit && dm_we) dmem[eff_idx] <= res.store_value;
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (commit) out_q <= res;
  end

  assign result.valid         = out_valid;
  assign result.next_pc       = out_q.next_pc;
  assign result.halted        = out_q.halted;
  assign result.reg_written   = out_q.reg_written;
  assign result.dest_reg      = out_q.dest_reg;
  assign result.reg_result    = out_q.reg_result;
  assign result.mem_written   = out_q.mem_written;
  assign result.store_address = out_q.store_address;
  assign result.store_value   = out_q.store_value;
  assign result.read_value    = out_q.read_value;
  assign result.instr_class   = out_q.instr_class;

endmodule
`default_nettype wire

// ===== hw/rtl/eight_bit_risc_instruction_executor.sv =====
// Top level of the eight-bit RISC instruction executor.
// Executes one 16-bit instruction (or one register or data byte access) per
// item and returns one result beat per item. A front end classifies each beat
// into a two-entry queue, so input beats keep being taken while the back end
// works. For each item the back end does a registered register-file read,
// then execute and commit; loads add a registered data store read
// before commit. The result sits in an output register, so the next item
// proceeds while a finished result waits. Reset takes effect at once: register
// file and data store read as zero until written, tracked by per-entry valid
// bits, with no clearing pass. Data addresses wrap modulo 256 and then modulo
// DATA_DEPTH.
`default_nettype none
module eight_bit_risc_instruction_executor #(
  parameter int DATA_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  erie_item_if.sink     item,
  erie_result_if.source result
);

  erie_pkg::q_beat_t push;
  erie_pkg::q_beat_t head;
  logic              full;
  logic              pop;

  erie_front u_front (
    .item (item),
    .full (full),
    .push (push)
  );

  erie_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  erie_back #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire

// ===== test/tb_eight_bit_risc_instruction_executor.sv =====
// Testbench for the eight-bit RISC executor: directed and random items against a predictor.
`default_nettype none
module tb_eight_bit_risc_instruction_executor;

  localparam int DATA_DEPTH  = 256;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;

  erie_item_if   item_bus ();
  erie_result_if result_bus ();

  eight_bit_risc_instruction_executor #(.DATA_DEPTH(DATA_DEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always #1 clk = ~clk;

  // Architectural state mirrored by the predictor
  logic [7:0] arch_regs [erie_pkg::REG_COUNT];
  logic [7:0] data_bytes [DATA_DEPTH];
  logic [7:0] arch_pc;
  logic       core_halted;

  erie_pkg::res_t pending_results [$];

  int unsigned source_gap_max = 11;
  int unsigned sink_gap_max   = 11;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned instrs_executed = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  // Apply one item to the mirrored state and return the result it should produce
  function automatic erie_pkg::res_t predict_result(logic [2:0] kind, logic [15:0] ir,
                                                    logic [3:0] sel, logic [7:0] addr,
                                                    logic [7:0] val);
    erie_pkg::res_t r;
    erie_pkg::op_t  op;
    logic [3:0]     rd;
    logic [3:0]     sh;
    logic [7:0]     a;
    logic [7:0]     b;
    logic [7:0]     res;
    logic [7:0]     ea;
    logic [7:0]     pc_next;
    logic           wr;
    r = '0;
    r.instr_class = erie_pkg::CLS_NONE;
    case (kind)
      erie_pkg::KIND_EXEC: begin
        if (!core_halted) begin
          instrs_executed++;
          op      = erie_pkg::op_t'({1'b0, ir[15:12]});
          rd      = ir[11:8];
          a       = arch_regs[ir[7:4]];
          b       = arch_regs[ir[3:0]];
          sh      = ir[3:0];
          ea      = a + {{4{ir[3]}}, ir[3:0]};
          pc_next = arch_pc + 8'd2;
          res     = '0;
          wr      = 1'b1;
          case (op)
            erie_pkg::OP_ADD: begin
              r.instr_class = erie_pkg::CLS_ARITH;
              res = a + b;
            end
            erie_pkg::OP_SUB: begin
              r.instr_class = erie_pkg::CLS_ARITH;
              res = a - b;
            end
            erie_pkg::OP_MUL: begin
              r.instr_class = erie_pkg::CLS_ARITH;
              res = a * b;
            end
            erie_pkg::OP_INC: begin
              r.instr_class = erie_pkg::CLS_ARITH;
              res = arch_regs[rd] + 8'd1;
            end
            erie_pkg::OP_AND: begin
              r.instr_class = erie_pkg::CLS_LOGIC;
              res = a & b;
            end
            erie_pkg::OP_OR: begin
              r.instr_class = erie_pkg::CLS_LOGIC;
              res = a | b;
            end
            erie_pkg::OP_XOR: begin
              r.instr_class = erie_pkg::CLS_LOGIC;
              res = a ^ b;
            end
            erie_pkg::OP_NOT: begin
              r.instr_class = erie_pkg::CLS_LOGIC;
              res = ~a;
            end
            erie_pkg::OP_SHL: begin
              r.instr_class = erie_pkg::CLS_SHIFT;
              res = (sh < 4'd8) ? a << sh : 8'd0;
            end
            erie_pkg::OP_SHR: begin
              r.instr_class = erie_pkg::CLS_SHIFT;
              res = (sh < 4'd8) ? a >> sh : 8'd0;
            end
            erie_pkg::OP_LI: begin
              r.instr_class = erie_pkg::CLS_MEM;
              res = ir[7:0];
            end
            erie_pkg::OP_LD: begin
              r.instr_class = erie_pkg::CLS_MEM;
              res = data_bytes[int'(ea) % DATA_DEPTH];
            end
            erie_pkg::OP_ST: begin
              r.instr_class = erie_pkg::CLS_MEM;
              wr = 1'b0;
              ea = 8'(int'(ea) % DATA_DEPTH);
              data_bytes[ea]  = arch_regs[rd];
              r.mem_written   = 1'b1;
              r.store_address = ea;
              r.store_value   = arch_regs[rd];
            end
            erie_pkg::OP_JMP: begin
              r.instr_class = erie_pkg::CLS_CTRL;
              wr = 1'b0;
              pc_next = pc_next + {ir[10:4], 1'b0};
            end
            erie_pkg::OP_BEQZ: begin
              r.instr_class = erie_pkg::CLS_CTRL;
              wr = 1'b0;
              if (arch_regs[rd] == 8'd0) pc_next = pc_next + {ir[6:0], 1'b0};
            end
            erie_pkg::OP_HALT: begin
              r.instr_class = erie_pkg::CLS_HALT;
              wr = 1'b0;
              core_halted = 1'b1;
            end
            default: ;
          endcase
          if (wr) begin
            arch_regs[rd] = res;
            r.reg_written = 1'b1;
            r.dest_reg    = rd;
            r.reg_result  = res;
          end
          arch_pc = pc_next;
        end
      end
      erie_pkg::KIND_WREG: begin
        arch_regs[sel] = val;
        r.reg_written  = 1'b1;
        r.dest_reg     = sel;
        r.reg_result   = val;
      end
      erie_pkg::KIND_WMEM: begin
        ea = 8'(int'(addr) % DATA_DEPTH);
        data_bytes[ea]  = val;
        r.mem_written   = 1'b1;
        r.store_address = ea;
        r.store_value   = val;
      end
      erie_pkg::KIND_RMEM: r.read_value = data_bytes[int'(addr) % DATA_DEPTH];
      erie_pkg::KIND_RREG: r.read_value = arch_regs[sel];
      default: ;
    endcase
    r.next_pc = arch_pc;
    r.halted  = core_halted;
    return r;
  endfunction

  // Send one beat after a random gap; valid stays high when the next beat follows at once
  task automatic send_item(logic [2:0] kind, logic [15:0] ir, logic [3:0] sel,
                           logic [7:0] addr, logic [7:0] val);
    int unsigned gap;
    gap = $urandom_range(0, source_gap_max);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.kind        <= kind;
    item_bus.instruction <= ir;
    item_bus.reg_select  <= sel;
    item_bus.mem_address <= addr;
    item_bus.load_value  <= val;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    pending_results.push_back(predict_result(kind, ir, sel, addr, val));
    items_sent++;
  endtask

  task automatic exec_instr(erie_pkg::op_t op, logic [3:0] f2, logic [3:0] f1, logic [3:0] f0);
    send_item(erie_pkg::KIND_EXEC, {op[3:0], f2, f1, f0}, 4'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic write_reg(logic [3:0] sel, logic [7:0] val);
    send_item(erie_pkg::KIND_WREG, 16'($urandom), sel, 8'($urandom), val);
  endtask

  task automatic read_reg(logic [3:0] sel);
    send_item(erie_pkg::KIND_RREG, 16'($urandom), sel, 8'($urandom), 8'($urandom));
  endtask

  task automatic write_byte(logic [7:0] addr, logic [7:0] val);
    send_item(erie_pkg::KIND_WMEM, 16'($urandom), 4'($urandom), addr, val);
  endtask

  task automatic read_byte(logic [7:0] addr);
    send_item(erie_pkg::KIND_RMEM, 16'($urandom), 4'($urandom), addr, 8'($urandom));
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly instructions without halt, the rest register and byte traffic and unused kinds
  task automatic send_random_item();
    int unsigned pick;
    logic [2:0]  kind;
    logic [15:0] ir;
    pick = $urandom_range(0, 99);
    ir   = 16'($urandom);
    if (pick < 60) begin
      kind = erie_pkg::KIND_EXEC;
      ir[15:12] = 4'($urandom_range(0, 14));
      // Load zeros now and then so branches get taken
      if (erie_pkg::op_t'({1'b0, ir[15:12]}) == erie_pkg::OP_LI &&
          $urandom_range(0, 3) == 0) begin
        ir[7:0] = 8'd0;
      end
    end else if (pick < 70) begin
      kind = erie_pkg::KIND_WREG;
    end else if (pick < 80) begin
      kind = erie_pkg::KIND_WMEM;
    end else if (pick < 87) begin
      kind = erie_pkg::KIND_RMEM;
    end else if (pick < 94) begin
      kind = erie_pkg::KIND_RREG;
    end else begin
      kind = 3'($urandom_range(5, 7));
    end
    send_item(kind, ir, 4'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_reset_state();
    read_reg(4'd15);
    read_byte(8'd255);
  endtask

  task automatic test_data_paths();
    write_reg(4'd15, 8'h7F);
    write_reg(4'd0, 8'h80);
    write_byte(8'd255, 8'h80);
    read_byte(8'd255);
    send_item(3'd5, 16'hFFFF, 4'hF, 8'hFF, 8'hFF);
    send_item(3'd7, 16'h0000, 4'h0, 8'h00, 8'h00);
  endtask

  task automatic test_instruction_set();
    exec_instr(erie_pkg::OP_ADD, 4'd1, 4'd15, 4'd0);
    exec_instr(erie_pkg::OP_SUB, 4'd2, 4'd0, 4'd15);
    exec_instr(erie_pkg::OP_MUL, 4'd3, 4'd15, 4'd15);
    exec_instr(erie_pkg::OP_INC, 4'd15, 4'd3, 4'd9);
    exec_instr(erie_pkg::OP_AND, 4'd4, 4'd1, 4'd0);
    exec_instr(erie_pkg::OP_OR, 4'd5, 4'd2, 4'd0);
    exec_instr(erie_pkg::OP_XOR, 4'd6, 4'd1, 4'd2);
    exec_instr(erie_pkg::OP_NOT, 4'd7, 4'd0, 4'd5);
    exec_instr(erie_pkg::OP_SHL, 4'd8, 4'd7, 4'd7);
    // shift amounts of eight and above clear the result
    exec_instr(erie_pkg::OP_SHL, 4'd9, 4'd7, 4'd8);
    exec_instr(erie_pkg::OP_SHR, 4'd10, 4'd0, 4'd15);
    exec_instr(erie_pkg::OP_LI, 4'd12, 4'h0, 4'h1);
    // base 1 plus offset -2 wraps to the top byte
    exec_instr(erie_pkg::OP_LD, 4'd13, 4'd12, 4'hE);
    exec_instr(erie_pkg::OP_ST, 4'd15, 4'd0, 4'h8);
    exec_instr(erie_pkg::OP_JMP, 4'h8, 4'h1, 4'h3);
    exec_instr(erie_pkg::OP_BEQZ, 4'd9, 4'h8, 4'h0);
    exec_instr(erie_pkg::OP_BEQZ, 4'd12, 4'h7, 4'hF);
  endtask

  task automatic test_random_program();
    for (int blk = 0; blk < 7; blk++) begin
      source_gap_max = (blk % 2 == 1) ? 11 : 0;
      sink_gap_max   = (blk % 4 >= 2) ? 11 : 0;
      for (int n = 0; n < 100; n++) send_random_item();
      if (blk == 3) drain_results();
    end
  endtask

  // Halt is permanent, so it runs last: instructions are then ignored, data paths still work
  task automatic test_halted_core();
    source_gap_max = 11;
    sink_gap_max   = 11;
    drain_results();
    exec_instr(erie_pkg::OP_HALT, 4'($urandom), 4'($urandom), 4'($urandom));
    exec_instr(erie_pkg::OP_ADD, 4'd1, 4'd2, 4'd3);
    exec_instr(erie_pkg::OP_JMP, 4'h7, 4'hF, 4'h0);
    write_reg(4'd3, 8'h55);
    read_reg(4'd3);
    write_byte(8'h10, 8'hAA);
    read_byte(8'h10);
    repeat (40) send_random_item();
  endtask

  // Receiver: hold ready low for a random number of cycles after each beat
  initial begin
    int unsigned stall;
    result_bus.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        stall = $urandom_range(0, sink_gap_max);
      end else if (stall != 0) begin
        stall--;
      end
      result_bus.ready <= (stall == 0);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    erie_pkg::res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing outstanding, expected none actual pc %0h",
               $time, result_bus.next_pc);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      check_field("next_pc", want.next_pc, result_bus.next_pc);
      check_field("halted", want.halted, result_bus.halted);
      check_field("reg_written", want.reg_written, result_bus.reg_written);
      check_field("dest_reg", want.dest_reg, result_bus.dest_reg);
      check_field("reg_result", want.reg_result, result_bus.reg_result);
      check_field("mem_written", want.mem_written, result_bus.mem_written);
      check_field("store_address", want.store_address, result_bus.store_address);
      check_field("store_value", want.store_value, result_bus.store_value);
      check_field("read_value", want.read_value, result_bus.read_value);
      check_field("instr_class", want.instr_class, result_bus.instr_class);
    end
  endtask

  // Check every result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) check_result();
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
          (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = 8'd0;
    foreach (data_bytes[i]) data_bytes[i] = 8'd0;
    arch_pc     = 8'd0;
    core_halted = 1'b0;
    rst                  = 1'b1;
    item_bus.valid       = 1'b0;
    item_bus.kind        = 3'd0;
    item_bus.instruction = 16'd0;
    item_bus.reg_select  = 4'd0;
    item_bus.mem_address = 8'd0;
    item_bus.load_value  = 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_data_paths();
    test_instruction_set();
    test_random_program();
    test_halted_core();

    // Drop valid, wait out the outstanding results, then let the pipeline settle
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d items, checked %0d results, %0d instructions executed before halt.",
             items_sent, results_checked, instrs_executed);
    $display("Mix: all opcodes, register and byte access, unused kinds, idle and stall phases.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
